// ----- design/gqs_pkg.sv -----
// Shared types and codes for the GF(2) quadratic system Gray-code search.
`timescale 1ns / 1ps
`default_nettype none

package gqs_pkg;

    typedef logic [2:0] t_kind;
    typedef logic [3:0] t_var;
    typedef logic [9:0] t_coeff;
    typedef logic [9:0] t_point;
    typedef logic [3:0] t_num_vars;

    localparam t_kind KIND_LOAD_CONST = 3'd0;
    localparam t_kind KIND_LOAD_LIN   = 3'd1;
    localparam t_kind KIND_LOAD_QUAD  = 3'd2;
    localparam t_kind KIND_START      = 3'd3;
    localparam t_kind KIND_STEP       = 3'd4;

    localparam t_num_vars NUM_VARS_RESET = 4'd10;

endpackage

`default_nettype wire

// ----- design/gqs_if.sv -----
// Valid/ready channel interfaces for command items and search results.
`timescale 1ns / 1ps
`default_nettype none

interface gqs_in_if import gqs_pkg::*; ();
    logic   valid;
    logic   ready;
    t_kind  kind;
    t_var   var_hi;
    t_var   var_lo;
    t_coeff coeff_word;

    modport source (output valid, kind, var_hi, var_lo, coeff_word, input ready);
    modport sink   (input valid, kind, var_hi, var_lo, coeff_word, output ready);
endinterface

interface gqs_out_if import gqs_pkg::*; ();
    logic   valid;
    logic   ready;
    t_point point;
    logic   is_root;
    logic   is_last;

    modport source (output valid, point, is_root, is_last, input ready);
    modport sink   (input valid, point, is_root, is_last, output ready);
endinterface

`default_nettype wire

// ----- design/gf2_quadratic_system_gray_search.sv -----
// Top level of the Gray-code exhaustive root search for quadratic systems over GF(2).
//
// Usage: command items arrive on i_in (valid/ready). Load items write the
// constant word, a linear word or a lower-triangle quadratic word. A start
// item rebuilds the first-difference memory from the linear words and the
// quadratic subdiagonal, one entry per cycle; i_in.ready stays low until the
// rebuild is done. Each step item of a running search produces one result on
// o_res: the current Gray point, the root flag (every polynomial zero) and
// the last-point flag. A step that is not the last reads the second-difference
// and the first-difference memory in its transfer cycle; the next cycle writes
// the updated first difference back and folds it into the parity word. No item
// is taken meanwhile, so back-to-back steps wait on this read-modify-write of
// the first-difference memory. The result leaves through an output register,
// valid in the cycle after the step transfer.
// A stalled receiver holds the result register; further items wait until the
// result is taken (or is taken in the same cycle). Steps outside a search,
// and unknown kinds, are dropped without a result.
// Reset: a clearing pass zeroes both memories with i_in.ready low; the APB
// port takes num_vars writes throughout.
`timescale 1ns / 1ps
`default_nettype none

module gf2_quadratic_system_gray_search import gqs_pkg::*; #(
    parameter int MAX_VARS  = 10,
    parameter int NUM_POLYS = 10
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    gqs_in_if.sink       i_in,
    gqs_out_if.source    o_res,
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [2:0]   paddr,
    input  wire  [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int VW       = $clog2(MAX_VARS);
    localparam int SD_DEPTH = MAX_VARS * MAX_VARS;
    localparam int SD_AW    = $clog2(SD_DEPTH);
    localparam int NV_W     = $clog2(MAX_VARS + 1);

    localparam logic ADDR_NUM_VARS = 1'b0;

    localparam logic [2:0] S_CLEAR     = 3'd0;
    localparam logic [2:0] S_IDLE      = 3'd1;
    localparam logic [2:0] S_BUILD     = 3'd2;
    localparam logic [2:0] S_BUILD_END = 3'd3;
    localparam logic [2:0] S_STEP2     = 3'd4;

    // Index of the single set bit of a one-hot word.
    function automatic logic [VW-1:0] onehot_to_index(input logic [MAX_VARS-1:0] oh);
        logic [VW-1:0] idx;
        idx = '0;
        for (int i = 0; i < MAX_VARS; i++) begin
            if (oh[i]) idx = idx | VW'(i);
        end
        return idx;
    endfunction

    // Control state.
    logic [2:0]           r_state, n_state;
    logic [SD_AW-1:0]     r_idx, n_idx;
    logic                 r_busy;
    t_num_vars            r_num_vars;
    logic [MAX_VARS-1:0]  r_cnt;
    logic [NUM_POLYS-1:0] r_parity;
    logic [NUM_POLYS-1:0] r_const;
    logic [NUM_POLYS-1:0] r_lin [MAX_VARS];
    logic [VW-1:0]        r_k1;
    logic                 r_k2v;

    // Result register.
    logic                 r_out_valid;
    t_point               r_point;
    logic                 r_is_root;
    logic                 r_is_last;

    // Difference memories and their registered read data.
    logic [NUM_POLYS-1:0] r_sd_mem [SD_DEPTH];
    logic [NUM_POLYS-1:0] r_fd_mem [MAX_VARS];
    logic [NUM_POLYS-1:0] r_sd_rdata;
    logic [NUM_POLYS-1:0] r_fd_rdata;

    // ---------------------------------------------------------------
    // Input decode
    // ---------------------------------------------------------------
    logic                 in_acc;
    logic [31:0]          word_ext;
    logic [NUM_POLYS-1:0] in_word;
    logic                 lin_ok;
    logic                 quad_ok;
    logic [SD_AW-1:0]     quad_addr;
    logic                 is_step;

    assign i_in.ready = (r_state == S_IDLE) && (!r_out_valid || o_res.ready);
    assign in_acc     = i_in.valid && i_in.ready;
    assign word_ext   = 32'(i_in.coeff_word);
    assign in_word    = word_ext[NUM_POLYS-1:0];
    assign lin_ok     = 32'(i_in.var_hi) < MAX_VARS;
    assign quad_ok    = lin_ok && (i_in.var_lo < i_in.var_hi);
    assign quad_addr  = SD_AW'(i_in.var_hi) * SD_AW'(MAX_VARS) + SD_AW'(i_in.var_lo);
    assign is_step    = in_acc && (i_in.kind == KIND_STEP) && r_busy;

    // ---------------------------------------------------------------
    // Step evaluation: end test, Gray point, next difference indexes
    // ---------------------------------------------------------------
    logic [NV_W-1:0]      vars_used;
    logic [MAX_VARS-1:0]  last_mask;
    logic                 at_end;
    logic [MAX_VARS-1:0]  gray;
    logic [31:0]          gray_ext;
    logic [MAX_VARS-1:0]  cnt_next;
    logic [MAX_VARS-1:0]  rest;
    logic [VW-1:0]        k1;
    logic [VW-1:0]        k2;
    logic                 k2_valid;

    always_comb begin
        if (r_num_vars == '0) begin
            vars_used = NV_W'(1);
        end else if (32'(r_num_vars) > MAX_VARS) begin
            vars_used = NV_W'(MAX_VARS);
        end else begin
            vars_used = NV_W'(r_num_vars);
        end
        for (int b = 0; b < MAX_VARS; b++) begin
            last_mask[b] = b < 32'(vars_used);
        end
    end

    assign at_end   = r_cnt >= last_mask;
    assign gray     = r_cnt ^ (r_cnt >> 1);
    assign gray_ext = 32'(gray);
    assign cnt_next = r_cnt + MAX_VARS'(1);
    assign rest     = cnt_next & (cnt_next - MAX_VARS'(1));
    assign k1       = onehot_to_index(cnt_next & (~cnt_next + MAX_VARS'(1)));
    assign k2       = onehot_to_index(rest & (~rest + MAX_VARS'(1)));
    assign k2_valid = rest != '0;

    // ---------------------------------------------------------------
    // Memory port control
    // ---------------------------------------------------------------
    logic                 sd_we;
    logic [SD_AW-1:0]     sd_waddr;
    logic [NUM_POLYS-1:0] sd_wdata;
    logic                 sd_re;
    logic [SD_AW-1:0]     sd_raddr;
    logic                 fd_we;
    logic [VW-1:0]        fd_waddr;
    logic [NUM_POLYS-1:0] fd_wdata;
    logic                 fd_re;
    logic [SD_AW-1:0]     bidx_m1;
    logic [VW-1:0]        build_widx;
    logic [NUM_POLYS-1:0] step_fd;

    assign bidx_m1    = r_idx - SD_AW'(1);
    assign build_widx = bidx_m1[VW-1:0];
    assign step_fd    = r_fd_rdata ^ (r_k2v ? r_sd_rdata : '0);
    assign fd_re      = is_step && !at_end;

    always_comb begin
        // Second differences: clearing pass or quadratic loads.
        sd_we    = 1'b0;
        sd_waddr = quad_addr;
        sd_wdata = in_word;
        if (r_state == S_CLEAR) begin
            sd_we    = 1'b1;
            sd_waddr = r_idx;
            sd_wdata = '0;
        end else if (in_acc && (i_in.kind == KIND_LOAD_QUAD) && quad_ok) begin
            sd_we = 1'b1;
        end

        // One read: subdiagonal during the build, step entry otherwise.
        sd_re    = 1'b0;
        sd_raddr = SD_AW'(k2) * SD_AW'(MAX_VARS) + SD_AW'(k1);
        if (r_state == S_BUILD) begin
            sd_re    = 1'b1;
            sd_raddr = (r_idx == '0) ? '0 : r_idx * SD_AW'(MAX_VARS) + bidx_m1;
        end else if (fd_re && k2_valid) begin
            sd_re = 1'b1;
        end

        // First differences: clear, build write-back, step write-back.
        fd_we    = 1'b0;
        fd_waddr = r_k1;
        fd_wdata = step_fd;
        case (r_state)
            S_CLEAR: begin
                fd_we    = 32'(r_idx) < MAX_VARS;
                fd_waddr = r_idx[VW-1:0];
                fd_wdata = '0;
            end
            S_BUILD, S_BUILD_END: begin
                fd_we    = (r_state == S_BUILD_END) || (r_idx != '0);
                fd_waddr = build_widx;
                fd_wdata = r_lin[build_widx] ^ ((build_widx == '0) ? '0 : r_sd_rdata);
            end
            S_STEP2: begin
                fd_we = 1'b1;
            end
            default: begin
                fd_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (sd_we) r_sd_mem[sd_waddr] <= sd_wdata;
        if (sd_re) r_sd_rdata <= r_sd_mem[sd_raddr];
        if (fd_we) r_fd_mem[fd_waddr] <= fd_wdata;
        if (fd_re) r_fd_rdata <= r_fd_mem[k1];
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            S_CLEAR: begin
                n_idx = r_idx + SD_AW'(1);
                if (r_idx == SD_AW'(SD_DEPTH - 1)) begin
                    n_state = S_IDLE;
                    n_idx   = '0;
                end
            end
            S_IDLE: begin
                if (in_acc && (i_in.kind == KIND_START)) begin
                    n_state = S_BUILD;
                    n_idx   = '0;
                end else if (fd_re) begin
                    n_state = S_STEP2;
                end
            end
            S_BUILD: begin
                n_idx = r_idx + SD_AW'(1);
                if (r_idx == SD_AW'(MAX_VARS - 1)) n_state = S_BUILD_END;
            end
            S_BUILD_END: begin
                n_state = S_IDLE;
            end
            S_STEP2: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_busy      <= 1'b0;
            r_num_vars  <= NUM_VARS_RESET;
            r_cnt       <= '0;
            r_parity    <= '0;
            r_const     <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < MAX_VARS; k++) r_lin[k] <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;

            // Register writes are taken in every state.
            if (psel && penable && pwrite && pready && (paddr[2] == ADDR_NUM_VARS)) begin
                r_num_vars <= pwdata[3:0];
            end

            if (in_acc && (i_in.kind == KIND_LOAD_CONST)) r_const <= in_word;
            if (in_acc && (i_in.kind == KIND_LOAD_LIN) && lin_ok) begin
                r_lin[VW'(i_in.var_hi)] <= in_word;
            end

            if (in_acc && (i_in.kind == KIND_START)) begin
                r_parity <= r_const;
                r_cnt    <= '0;
                r_busy   <= 1'b1;
            end

            // Step: end the search on the last point, else advance the counter.
            if (is_step) begin
                if (at_end) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= cnt_next;
                end
            end

            if (r_state == S_STEP2) r_parity <= r_parity ^ step_fd;

            // Hold the result until transfer; a new one may replace it at once.
            if (is_step) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Step bookkeeping and result payload.
    always_ff @(posedge i_clk) begin
        if (fd_re) begin
            r_k1  <= k1;
            r_k2v <= k2_valid;
        end
        if (is_step) begin
            r_point   <= gray_ext[9:0];
            r_is_root <= r_parity == '0;
            r_is_last <= at_end;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.point   = r_point;
    assign o_res.is_root = r_is_root;
    assign o_res.is_last = r_is_last;

    // ---------------------------------------------------------------
    // Configuration read-back
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_NUM_VARS) ? 32'(r_num_vars) : '0;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_step_writeback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP2) |=> (r_state == S_IDLE))
        else $error("step write-back did not return to idle");

    a_step_enters_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_step && !at_end) |=> (r_state == S_STEP2) && r_out_valid && !r_is_last)
        else $error("advancing step missed its write-back cycle");

    a_result_from_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_busy))
        else $error("result produced outside a search");

    a_last_ends_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_is_last) |-> !r_busy)
        else $error("search still running after the last point");

    a_build_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BUILD_END) |=> (r_state == S_IDLE) && r_busy)
        else $error("build finished without an active search");

endmodule

`default_nettype wire

// ----- verif/gqs_tb_pkg.sv -----
// Testbench constants for the Gray-code search: register map, sizes and spare command kinds.
`timescale 1ns / 1ps

package gqs_tb_pkg;

    import gqs_pkg::*;

    localparam int TB_MAX_VARS  = 10;
    localparam int TB_NUM_POLYS = 10;

    localparam logic [2:0] ADDR_NUM_VARS = 3'd0;

    // Kinds the block has no use for; it drops them
    localparam t_kind KIND_SPARE_5 = 3'd5;
    localparam t_kind KIND_SPARE_6 = 3'd6;
    localparam t_kind KIND_SPARE_7 = 3'd7;

    // Clamp a num_vars setting to the range the search really uses
    function automatic int effective_vars(input t_num_vars setting);
        if (setting < 1) return 1;
        if (setting > TB_MAX_VARS) return TB_MAX_VARS;
        return int'(setting);
    endfunction

endpackage

// ----- verif/gqs_checker.sv -----
// Watches the command and result channels, predicts each search result and compares it.
`timescale 1ns / 1ps

module gqs_checker import gqs_pkg::*; import gqs_tb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gqs_in_if           in_ch,
    gqs_out_if          res_ch,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_mismatches,
    output int          o_outstanding,
    output int          o_results,
    output int          o_roots,
    output int          o_search_ends
);

    localparam int     MAX_REPORTS = 10;
    localparam t_coeff WORD_MASK   = t_coeff'((1 << TB_NUM_POLYS) - 1);

    typedef struct packed {
        t_point point;
        logic   is_root;
        logic   is_last;
    } gray_result_t;

    gray_result_t           expected_q[$];
    t_num_vars              num_vars_reg;
    logic [TB_MAX_VARS-1:0] gray_count;
    t_coeff                 parity;
    t_coeff                 const_word;
    t_coeff                 linear_word[TB_MAX_VARS];
    t_coeff                 first_diff[TB_MAX_VARS];
    t_coeff                 second_diff[TB_MAX_VARS][TB_MAX_VARS];
    logic                   searching;

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
        o_results     = 0;
        o_roots       = 0;
        o_search_ends = 0;
    end

    function automatic int low_bit(input logic [TB_MAX_VARS-1:0] v);
        for (int k = 0; k < TB_MAX_VARS; k++) begin
            if (v[k]) return k;
        end
        return -1;
    endfunction

    task automatic apply_command(input t_kind kind, input t_var hi, input t_var lo,
                                 input t_coeff word_in);
        t_coeff                 word;
        int                     k1;
        int                     k2;
        logic [TB_MAX_VARS-1:0] last_count;
        logic [TB_MAX_VARS-1:0] rest;
        gray_result_t           r;
        word = word_in & WORD_MASK;
        case (kind)
            KIND_LOAD_CONST: begin
                const_word = word;
            end
            KIND_LOAD_LIN: begin
                if (hi < TB_MAX_VARS) linear_word[hi] = word;
            end
            KIND_LOAD_QUAD: begin
                if (hi < TB_MAX_VARS && lo < hi) second_diff[hi][lo] = word;
            end
            KIND_START: begin
                first_diff[0] = linear_word[0];
                for (int k = 1; k < TB_MAX_VARS; k++)
                    first_diff[k] = linear_word[k] ^ second_diff[k][k-1];
                parity     = const_word;
                gray_count = '0;
                searching  = 1'b1;
            end
            KIND_STEP: begin
                if (searching) begin
                    last_count = {TB_MAX_VARS{1'b1}} >> (TB_MAX_VARS - effective_vars(num_vars_reg));
                    r.point    = gray_count ^ (gray_count >> 1);
                    r.is_root  = ((parity & WORD_MASK) == '0);
                    r.is_last  = (gray_count >= last_count);
                    expected_q.push_back(r);
                    if (r.is_last) begin
                        searching = 1'b0;
                    end else begin
                        gray_count = gray_count + 1'b1;
                        k1   = low_bit(gray_count);
                        rest = gray_count & (gray_count - 1'b1);
                        k2   = low_bit(rest);
                        if (k1 >= 0) begin
                            if (k2 >= 0) first_diff[k1] = first_diff[k1] ^ second_diff[k2][k1];
                            parity = (parity ^ first_diff[k1]) & WORD_MASK;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_result(input t_point point, input logic is_root, input logic is_last);
        gray_result_t want;
        if (expected_q.size() == 0) begin
            if (o_mismatches < MAX_REPORTS)
                $display("unexpected result: point %03h root %0b last %0b",
                         point, is_root, is_last);
            o_mismatches++;
        end else begin
            want = expected_q.pop_front();
            if (want.point !== point || want.is_root !== is_root || want.is_last !== is_last) begin
                if (o_mismatches < MAX_REPORTS)
                    $display("mismatch: expected point %03h root %0b last %0b, got point %03h root %0b last %0b",
                             want.point, want.is_root, want.is_last, point, is_root, is_last);
                o_mismatches++;
            end
            o_results++;
            if (is_root === 1'b1) o_roots++;
            if (is_last === 1'b1) o_search_ends++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            num_vars_reg = NUM_VARS_RESET;
            gray_count   = '0;
            parity       = '0;
            const_word   = '0;
            searching    = 1'b0;
            for (int k = 0; k < TB_MAX_VARS; k++) begin
                linear_word[k] = '0;
                first_diff[k]  = '0;
                for (int j = 0; j < TB_MAX_VARS; j++) second_diff[k][j] = '0;
            end
            expected_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == ADDR_NUM_VARS)
                num_vars_reg = i_pwdata[3:0];
            if (in_ch.valid && in_ch.ready)
                apply_command(in_ch.kind, in_ch.var_hi, in_ch.var_lo, in_ch.coeff_word);
            if (res_ch.valid && res_ch.ready)
                check_result(res_ch.point, res_ch.is_root, res_ch.is_last);
        end
        o_outstanding = expected_q.size();
    end

endmodule

// ----- verif/tb_top.sv -----
// Top of the testbench: clock, reset, command stimulus, result stalls and the verdict.
`timescale 1ns / 1ps

module tb_top;

    import gqs_pkg::*;
    import gqs_tb_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RESET_CYCLES  = 11;
    // Start rebuilds the first differences while i_in.ready is low; a dropped step
    // may still be in flight when the last result leaves. Wait this long before writes.
    localparam int SETTLE_CYCLES = TB_MAX_VARS + 6;
    localparam int RANDOM_ITEMS  = 800;

    typedef enum {STALL_NONE, STALL_COIN, STALL_RUNS} stall_mode_t;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int outstanding;
    int results;
    int roots;
    int search_ends;
    int items_sent;
    int burst_left;
    int writes_done;

    gqs_in_if  in_ch();
    gqs_out_if res_ch();

    always begin
        #1 i_clk = 1'b0;
        #1 i_clk = 1'b1;
    end

    gf2_quadratic_system_gray_search #(
        .MAX_VARS  (TB_MAX_VARS),
        .NUM_POLYS (TB_NUM_POLYS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    gqs_checker u_search_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .in_ch         (in_ch),
        .res_ch        (res_ch),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_results     (results),
        .o_roots       (roots),
        .o_search_ends (search_ends)
    );

    function automatic t_var rand_var();
        return t_var'($urandom_range(0, 15));
    endfunction

    function automatic t_coeff rand_word();
        return t_coeff'($urandom);
    endfunction

    // Choose which polynomials carry coefficients this phase. Sparse systems
    // keep roots common; the empty one makes every point a root.
    function automatic t_coeff pick_poly_mask();
        t_coeff m;
        m = '0;
        case ($urandom_range(0, 5))
            0: begin
            end
            1: begin
                m[$urandom_range(0, 9)] = 1'b1;
            end
            2: begin
                m[$urandom_range(0, 9)] = 1'b1;
                m[$urandom_range(0, 9)] = 1'b1;
            end
            3: begin
                m[$urandom_range(0, 9)] = 1'b1;
                m[$urandom_range(0, 9)] = 1'b1;
                m[$urandom_range(0, 9)] = 1'b1;
            end
            4: begin
                m = '1;
            end
            default: begin
                m = rand_word();
            end
        endcase
        return m;
    endfunction

    // Receiver: switch between always ready, coin-flip ready and long stall runs.
    initial begin : res_ready_pattern
        stall_mode_t mode;
        int          mode_left;
        int          run_left;
        logic        level;
        res_ch.ready = 1'b0;
        mode         = STALL_NONE;
        mode_left    = 0;
        run_left     = 0;
        level        = 1'b0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                mode      = stall_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
                STALL_NONE: begin
                    res_ch.ready <= 1'b1;
                end
                STALL_COIN: begin
                    res_ch.ready <= 1'($urandom_range(0, 1));
                end
                default: begin
                    if (run_left == 0) begin
                        level    = !level;
                        run_left = level ? $urandom_range(1, 3) : $urandom_range(1, 12);
                    end
                    run_left--;
                    res_ch.ready <= level;
                end
            endcase
        end
    end

    // Send one command. Called and returning just after a falling edge; the
    // sender runs in bursts, and a gap opens only when a burst is used up.
    task automatic push_cmd(input t_kind kind, input t_var hi, input t_var lo, input t_coeff word);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= kind;
        in_ch.var_hi     <= hi;
        in_ch.var_lo     <= lo;
        in_ch.coeff_word <= word;
        // Hold the command until the transfer edge
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    // Drop valid, wait for every expected result, then let in-flight work settle.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        burst_left = 0;
    endtask

    // Setup cycle, then access cycle; the write lands at the edge with pready high.
    task automatic write_num_vars(input t_num_vars value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_NUM_VARS;
        pwdata  <= {28'($urandom), value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        writes_done++;
    endtask

    // Any kind, start only if allowed: spare kinds, bad indices, loads mid-search, stray steps.
    task automatic push_noise(input bit allow_start);
        t_kind kind;
        t_var  hi;
        t_var  lo;
        kind = t_kind'($urandom_range(0, 7));
        if (kind == KIND_START && !allow_start) kind = KIND_LOAD_QUAD;
        hi = rand_var();
        lo = rand_var();
        if (kind == KIND_LOAD_QUAD && $urandom_range(0, 1) == 1) begin
            hi = t_var'($urandom_range(1, TB_MAX_VARS - 1));
            lo = t_var'($urandom_range(0, hi - 1));
        end
        push_cmd(kind, hi, lo, rand_word());
    endtask

    // Load constant, linear words and every quadratic pair among the active variables.
    task automatic load_system(input int n_eff, input t_coeff mask);
        t_coeff qword;
        push_cmd(KIND_LOAD_CONST, rand_var(), rand_var(), rand_word() & mask);
        for (int v = 0; v < n_eff; v++) begin
            push_cmd(KIND_LOAD_LIN, t_var'(v), rand_var(), rand_word() & mask);
            for (int u = 0; u < v; u++) begin
                qword = ($urandom_range(0, 3) == 0) ? '0 : (rand_word() & mask);
                push_cmd(KIND_LOAD_QUAD, t_var'(v), t_var'(u), qword);
            end
            if ($urandom_range(0, 7) == 0) push_noise(1'b0);
        end
    endtask

    // One search: set num_vars while idle, load, start and step to the end.
    // When cut short, stop partway, lower num_vars and step into the early end.
    task automatic run_phase(input t_num_vars setting, input bit cut_short);
        int n_eff;
        int steps;
        bit restarts;
        wait_idle();
        write_num_vars(setting);
        n_eff    = effective_vars(setting);
        restarts = (n_eff <= 6);
        load_system(n_eff, pick_poly_mask());
        push_cmd(KIND_START, rand_var(), rand_var(), rand_word());
        steps = cut_short ? $urandom_range(20, 60) : (1 << n_eff) + $urandom_range(0, 2);
        repeat (steps) begin
            if ($urandom_range(0, 9) == 0) push_noise(restarts);
            push_cmd(KIND_STEP, rand_var(), rand_var(), rand_word());
        end
        if (cut_short) begin
            wait_idle();
            write_num_vars(t_num_vars'($urandom_range(1, 4)));
            repeat (3) push_cmd(KIND_STEP, rand_var(), rand_var(), rand_word());
        end
    endtask

    initial begin : stimulus
        int random_start;
        in_ch.valid      = 1'b0;
        in_ch.kind       = KIND_LOAD_CONST;
        in_ch.var_hi     = '0;
        in_ch.var_lo     = '0;
        in_ch.coeff_word = '0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = ADDR_NUM_VARS;
        pwdata           = '0;
        items_sent       = 0;
        burst_left       = 0;
        writes_done      = 0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part on a two-variable search. Commands wait out the
        // clearing pass through the handshake; the APB port is open at once.
        write_num_vars(t_num_vars'(2));
        push_cmd(KIND_STEP, 4'd0, 4'd0, 10'h000);          // idle step, dropped
        push_cmd(KIND_SPARE_5, 4'd15, 4'd15, 10'h3FF);
        push_cmd(KIND_SPARE_6, 4'd0, 4'd0, 10'h000);
        push_cmd(KIND_SPARE_7, 4'd9, 4'd9, 10'h155);
        push_cmd(KIND_LOAD_CONST, 4'd0, 4'd0, 10'h3FF);
        push_cmd(KIND_LOAD_LIN, 4'd0, 4'd0, 10'h3FF);
        push_cmd(KIND_LOAD_LIN, 4'd1, 4'd0, 10'h001);
        push_cmd(KIND_LOAD_LIN, 4'd9, 4'd0, 10'h200);
        push_cmd(KIND_LOAD_LIN, 4'd10, 4'd0, 10'h3FF);     // bad index
        push_cmd(KIND_LOAD_LIN, 4'd15, 4'd15, 10'h3FF);    // bad index
        push_cmd(KIND_LOAD_QUAD, 4'd1, 4'd0, 10'h2AA);
        push_cmd(KIND_LOAD_QUAD, 4'd9, 4'd8, 10'h3FF);
        push_cmd(KIND_LOAD_QUAD, 4'd5, 4'd5, 10'h3FF);     // lower not below higher
        push_cmd(KIND_LOAD_QUAD, 4'd3, 4'd7, 10'h3FF);     // indices swapped
        push_cmd(KIND_LOAD_QUAD, 4'd15, 4'd2, 10'h3FF);    // higher out of range
        push_cmd(KIND_LOAD_QUAD, 4'd10, 4'd9, 10'h3FF);    // higher out of range
        push_cmd(KIND_START, 4'd15, 4'd15, 10'h3FF);
        push_cmd(KIND_STEP, 4'd15, 4'd15, 10'h3FF);
        push_cmd(KIND_STEP, 4'd0, 4'd0, 10'h000);
        push_cmd(KIND_LOAD_CONST, 4'd0, 4'd0, 10'h000);    // mid-search, waits for start
        push_cmd(KIND_START, 4'd0, 4'd0, 10'h000);         // restart from point zero
        repeat (4) push_cmd(KIND_STEP, rand_var(), rand_var(), rand_word());
        push_cmd(KIND_STEP, 4'd0, 4'd0, 10'h000);          // after the end, dropped

        // One exhaustive search at the widest setting reaches the top counter bits
        run_phase(t_num_vars'(TB_MAX_VARS), 1'b0);

        // Random part: settings at the extremes first, then mostly small searches
        random_start = items_sent;
        run_phase(t_num_vars'(1), 1'b0);
        run_phase(t_num_vars'(0), 1'b0);
        run_phase(t_num_vars'(15), 1'b1);
        run_phase(t_num_vars'(3), 1'b0);
        run_phase(t_num_vars'(11), 1'b1);
        run_phase(t_num_vars'(4), 1'b0);
        while (items_sent - random_start < RANDOM_ITEMS) begin
            case ($urandom_range(0, 19))
                0:       run_phase(t_num_vars'($urandom_range(11, 15)), 1'b1);
                1:       run_phase(t_num_vars'($urandom_range(9, 10)), 1'b1);
                2, 3:    run_phase(t_num_vars'($urandom_range(6, 7)), 1'b0);
                default: run_phase(t_num_vars'($urandom_range(0, 5)), 1'b0);
            endcase
        end

        wait_idle();
        $display("run covered %0d commands and %0d num_vars writes", items_sent, writes_done);
        $display("checked %0d results: %0d roots, %0d search ends, %0d mismatches",
                 results, roots, search_ends, mismatches);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog: end the run if it outlasts CYCLE_LIMIT
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results still outstanding", cycles, outstanding);
        $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
design/gqs_pkg.sv
design/gqs_if.sv
design/gf2_quadratic_system_gray_search.sv
verif/gqs_tb_pkg.sv
verif/gqs_checker.sv
verif/tb_top.sv
